[rtl/lsre_pkg.sv]
// Package for the link-state route engine: sizes, command codes and types.
// Used by link_state_route_engine; depends on nothing.
package lsre_pkg;
    localparam int NODES = 32;
    localparam int NW = $clog2(NODES);
    localparam int AW = 2 * NW;
    localparam int DW = 21;
    localparam logic [DW-1:0] DIST_MAX = {DW{1'b1}};

    typedef enum logic [1:0] {
        CMD_SET    = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_QUERY  = 2'd2,
        CMD_NONE   = 2'd3
    } cmd_t;
endpackage

[rtl/link_state_route_engine.sv]
// Link-state route engine top level: cost matrix memory and search sequencer.
// Depends on lsre_pkg.
//
// Usage: requests enter on the in channel (in_valid/in_ready) with cmd, node_a,
// node_b and link_cost. An in-range set or remove request writes the link in both
// directions, the second one from S_WR2, and gives no result. A route query
// gives one result on the out channel (out_valid/out_ready): reachable,
// distance and next_hop.
// A query to itself or out of range gives its result in the cycle after it is
// accepted. A full query runs up to NODES passes; each pass scans all NODES
// distances to pick the next router and then relaxes its row of the cost
// matrix through the single memory read port. The query then walks the
// predecessor chain back to the source. One request is in work at a time;
// in_ready is low while a request is in work or a result waits.
// After reset a clearing pass writes zero to every one of the NODES*NODES
// matrix entries, one a cycle, with in_ready low.
// A stalled receiver holds the result in the output register.
module link_state_route_engine (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [1:0]              cmd,
    input  logic [4:0]              node_a,
    input  logic [4:0]              node_b,
    input  logic [15:0]             link_cost,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic                    reachable,
    output logic [lsre_pkg::DW-1:0] distance,
    output logic [4:0]              next_hop
);
    import lsre_pkg::*;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_WR2, S_INIT, S_SEL, S_RELAX, S_WALK, S_OUT
    } state_t;

    state_t         state_reg;
    logic [AW:0]    clr_reg;
    logic [NW:0]    cnt_reg;
    logic [NW-1:0]  a_reg, b_reg;
    logic [15:0]    cost_reg;
    logic [NW-1:0]  u_reg;
    logic           u_ok_reg;
    logic [DW-1:0]  ubest_reg;
    logic [NW-1:0]  hop_reg;
    logic [NW-1:0]  rd_i_reg;
    logic           rd_v_reg;
    logic           out_valid_reg;
    logic           reach_reg;
    logic [DW-1:0]  dist_reg;
    logic [4:0]     nhop_reg;

    logic [15:0]    mem [NODES*NODES];
    logic [15:0]    rdata_reg;
    logic [DW-1:0]  best [NODES];
    logic [NW:0]    pred [NODES];
    logic [NODES-1:0] done_reg, reach_bits_reg;

    logic           in_range;
    logic [AW-1:0]  rd_addr;
    logic           rd_en;
    logic [DW:0]    nd_wide;
    logic [DW-1:0]  nd;

    assign in_range = ({3'b0, node_a} < 8'(NODES)) && ({3'b0, node_b} < 8'(NODES));
    assign in_ready = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign reachable = reach_reg;
    assign distance = dist_reg;
    assign next_hop = nhop_reg;

    assign rd_en = (state_reg == S_RELAX) && !cnt_reg[NW];
    assign rd_addr = {u_reg, cnt_reg[NW-1:0]};
    assign nd_wide = {1'b0, ubest_reg} + {{(DW-15){1'b0}}, rdata_reg};
    assign nd = nd_wide[DW] ? DIST_MAX : nd_wide[DW-1:0];

    always_ff @(posedge clk)
    begin
        if (state_reg == S_CLEAR)
        begin
            mem[clr_reg[AW-1:0]] <= '0;
        end
        else if (state_reg == S_IDLE && in_valid && in_range &&
                 (cmd == CMD_SET || cmd == CMD_REMOVE))
        begin
            mem[{node_a[NW-1:0], node_b[NW-1:0]}] <=
                (cmd == CMD_SET) ? link_cost : 16'd0;
        end
        else if (state_reg == S_WR2)
        begin
            mem[{b_reg, a_reg}] <= cost_reg;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_RELAX && rd_v_reg && rdata_reg != 16'd0)
        begin
            if (!reach_bits_reg[rd_i_reg] || nd < best[rd_i_reg])
            begin
                best[rd_i_reg] <= nd;
                pred[rd_i_reg] <= {1'b0, u_reg};
            end
            else if (nd == best[rd_i_reg] && {1'b0, u_reg} < pred[rd_i_reg])
            begin
                pred[rd_i_reg] <= {1'b0, u_reg};
            end
        end
        else if (state_reg == S_INIT)
        begin
            best[a_reg] <= '0;
            pred[a_reg] <= (NW+1)'(NODES);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg <= '0;
            cnt_reg <= '0;
            out_valid_reg <= 1'b0;
            done_reg <= '0;
            reach_bits_reg <= '0;
            rd_v_reg <= 1'b0;
            u_ok_reg <= 1'b0;
        end
        else
        begin
            rd_v_reg <= rd_en;
            rd_i_reg <= cnt_reg[NW-1:0];
            unique case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == (AW+1)'(NODES*NODES-1))
                        state_reg <= S_IDLE;
                end
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        a_reg <= node_a[NW-1:0];
                        b_reg <= node_b[NW-1:0];
                        cost_reg <= (cmd == CMD_SET) ? link_cost : 16'd0;
                        unique case (cmd)
                            CMD_SET, CMD_REMOVE:
                                state_reg <= in_range ? S_WR2 : S_IDLE;
                            CMD_QUERY:
                            begin
                                reach_reg <= in_range && node_a == node_b;
                                dist_reg <= '0;
                                nhop_reg <= (in_range && node_a == node_b) ? node_a : 5'd0;
                                state_reg <= (in_range && node_a != node_b) ? S_INIT : S_OUT;
                                out_valid_reg <= !(in_range && node_a != node_b);
                            end
                            default: state_reg <= S_IDLE;
                        endcase
                    end
                end
                S_WR2: state_reg <= S_IDLE;
                S_INIT:
                begin
                    done_reg <= '0;
                    reach_bits_reg <= {{(NODES-1){1'b0}}, 1'b1} << a_reg;
                    cnt_reg <= '0;
                    u_ok_reg <= 1'b0;
                    state_reg <= S_SEL;
                end
                S_SEL:
                begin
                    if (cnt_reg[NW])
                    begin
                        cnt_reg <= '0;
                        if (u_ok_reg)
                        begin
                            done_reg[u_reg] <= 1'b1;
                            ubest_reg <= best[u_reg];
                            state_reg <= S_RELAX;
                        end
                        else
                        begin
                            hop_reg <= b_reg;
                            state_reg <= S_WALK;
                        end
                    end
                    else
                    begin
                        if (reach_bits_reg[cnt_reg[NW-1:0]] && !done_reg[cnt_reg[NW-1:0]] &&
                            (!u_ok_reg || best[cnt_reg[NW-1:0]] < best[u_reg]))
                        begin
                            u_reg <= cnt_reg[NW-1:0];
                            u_ok_reg <= 1'b1;
                        end
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                S_RELAX:
                begin
                    if (rd_v_reg && rdata_reg != 16'd0)
                        reach_bits_reg[rd_i_reg] <= 1'b1;
                    if (!cnt_reg[NW])
                        cnt_reg <= cnt_reg + 1'b1;
                    else if (!rd_v_reg)
                    begin
                        cnt_reg <= '0;
                        u_ok_reg <= 1'b0;
                        state_reg <= S_SEL;
                    end
                end
                S_WALK:
                begin
                    if (!reach_bits_reg[b_reg])
                    begin
                        reach_reg <= 1'b0;
                        dist_reg <= '0;
                        nhop_reg <= 5'd0;
                        out_valid_reg <= 1'b1;
                        state_reg <= S_OUT;
                    end
                    else if (cnt_reg[NW] || pred[hop_reg][NW] ||
                             pred[hop_reg][NW-1:0] == a_reg)
                    begin
                        reach_reg <= 1'b1;
                        dist_reg <= best[b_reg];
                        nhop_reg <= 5'(hop_reg);
                        out_valid_reg <= 1'b1;
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        hop_reg <= pred[hop_reg][NW-1:0];
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                S_OUT:
                begin
                    if (out_ready)
                    begin
                        out_valid_reg <= 1'b0;
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    a_out_only_in_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> state_reg == S_OUT) else $error("result outside output state");
    a_no_ready_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready) else $error("ready while result waits");
    a_zero_when_unreach: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !reachable) |-> (distance == '0 && next_hop == 5'd0))
        else $error("unreachable result carries data");
endmodule
